// ===== hw/rtl/perspective_project_viewport_assert.svh =====
// Assertion macros shared by the vertex projection RTL.
`ifndef PERSPECTIVE_PROJECT_VIEWPORT_ASSERT_SVH
`define PERSPECTIVE_PROJECT_VIEWPORT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define PPV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("projection assertion failed");
// Check a property on every rising clock edge, reset included.
`define PPV_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("projection assertion failed");
`else
`define PPV_ASSERT(lbl, clk, rst, prop)
`define PPV_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/ppv_pkg.sv =====
// Shared types, constants, step program and saturation helpers for the projection engine.
package ppv_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int STORE_DEPTH       = 24;
  localparam int IDX_W             = 5;
  localparam int STEP_W            = 6;

  localparam logic [STEP_W-1:0] STEP_EZ_DONE = 6'd11;
  localparam logic [STEP_W-1:0] STEP_FIRST_W = 6'd28;
  localparam logic [STEP_W-1:0] STEP_LAST    = 6'd33;

  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_PROJECT = 1'b1
  } ppv_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_WAIT,
    ST_OUT
  } ppv_state_t;

  typedef enum logic [2:0] {
    A_MEM, A_CX, A_CY, A_TX, A_TY, A_D
  } ppv_asel_t;

  typedef enum logic [3:0] {
    B_X, B_Y, B_Z, B_ONE, B_HALF, B_NEG, B_EX, B_EY, B_EZ, B_HX, B_HY, B_CZ, B_W
  } ppv_bsel_t;

  typedef enum logic [1:0] {
    BASE_ZERO, BASE_DST, BASE_HX, BASE_HY
  } ppv_base_t;

  typedef enum logic {
    OP_ADD, OP_SUB
  } ppv_op_t;

  typedef enum logic [3:0] {
    R_EX, R_EY, R_EZ, R_CX, R_CY, R_CZ, R_HX, R_HY, R_TX, R_TY, R_SX, R_SY, R_D
  } ppv_dst_t;

  // One step: read a coefficient, multiply A by B, add to or subtract from a base.
  typedef struct packed {
    logic [IDX_W-1:0] addr;
    ppv_asel_t        asel;
    ppv_bsel_t        bsel;
    ppv_base_t        base;
    ppv_op_t          op;
    ppv_dst_t         dst;
  } ppv_uop_t;

  // Clamp a shifted 64-bit product to 32 bits.
  function automatic logic signed [31:0] sat_wide(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return INT_MAX;
    if (v < -64'sh0000_0000_8000_0000) return INT_MIN;
    return v[31:0];
  endfunction

  // Clamp a 33-bit sum to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? INT_MIN : INT_MAX;
    return v[31:0];
  endfunction

  function automatic ppv_uop_t ppv_mk(input logic [IDX_W-1:0] addr, input ppv_asel_t asel,
                                      input ppv_bsel_t bsel, input ppv_base_t base,
                                      input ppv_op_t op, input ppv_dst_t dst);
    ppv_uop_t u;
    u.addr = addr;
    u.asel = asel;
    u.bsel = bsel;
    u.base = base;
    u.op   = op;
    u.dst  = dst;
    return u;
  endfunction

  // Step program of one project transaction.
  // Store map: matrix 0-11, projection terms 12-17, viewport terms 18-23.
  function automatic ppv_uop_t ppv_prog(input logic [STEP_W-1:0] step);
    ppv_uop_t u;
    case (step)
      // eye space rows
      6'd0:  u = ppv_mk(5'd0,  A_MEM, B_X,    BASE_ZERO, OP_ADD, R_EX);
      6'd1:  u = ppv_mk(5'd1,  A_MEM, B_Y,    BASE_DST,  OP_ADD, R_EX);
      6'd2:  u = ppv_mk(5'd2,  A_MEM, B_Z,    BASE_DST,  OP_ADD, R_EX);
      6'd3:  u = ppv_mk(5'd3,  A_MEM, B_ONE,  BASE_DST,  OP_ADD, R_EX);
      6'd4:  u = ppv_mk(5'd4,  A_MEM, B_X,    BASE_ZERO, OP_ADD, R_EY);
      6'd5:  u = ppv_mk(5'd5,  A_MEM, B_Y,    BASE_DST,  OP_ADD, R_EY);
      6'd6:  u = ppv_mk(5'd6,  A_MEM, B_Z,    BASE_DST,  OP_ADD, R_EY);
      6'd7:  u = ppv_mk(5'd7,  A_MEM, B_ONE,  BASE_DST,  OP_ADD, R_EY);
      6'd8:  u = ppv_mk(5'd8,  A_MEM, B_X,    BASE_ZERO, OP_ADD, R_EZ);
      6'd9:  u = ppv_mk(5'd9,  A_MEM, B_Y,    BASE_DST,  OP_ADD, R_EZ);
      6'd10: u = ppv_mk(5'd10, A_MEM, B_Z,    BASE_DST,  OP_ADD, R_EZ);
      6'd11: u = ppv_mk(5'd11, A_MEM, B_ONE,  BASE_DST,  OP_ADD, R_EZ);
      // clip x, y, z
      6'd12: u = ppv_mk(5'd12, A_MEM, B_EX,   BASE_ZERO, OP_ADD, R_CX);
      6'd13: u = ppv_mk(5'd13, A_MEM, B_EZ,   BASE_DST,  OP_ADD, R_CX);
      6'd14: u = ppv_mk(5'd14, A_MEM, B_EY,   BASE_ZERO, OP_ADD, R_CY);
      6'd15: u = ppv_mk(5'd15, A_MEM, B_EZ,   BASE_DST,  OP_ADD, R_CY);
      6'd16: u = ppv_mk(5'd16, A_MEM, B_EZ,   BASE_ZERO, OP_ADD, R_CZ);
      6'd17: u = ppv_mk(5'd17, A_MEM, B_ONE,  BASE_DST,  OP_ADD, R_CZ);
      // viewport terms that need no reciprocal
      6'd18: u = ppv_mk(5'd20, A_MEM, B_HALF, BASE_ZERO, OP_ADD, R_HX);
      6'd19: u = ppv_mk(5'd0,  A_CX,  B_HX,   BASE_ZERO, OP_ADD, R_TX);
      6'd20: u = ppv_mk(5'd18, A_MEM, B_ONE,  BASE_HX,   OP_ADD, R_SX);
      6'd21: u = ppv_mk(5'd21, A_MEM, B_HALF, BASE_ZERO, OP_ADD, R_HY);
      6'd22: u = ppv_mk(5'd0,  A_CY,  B_NEG,  BASE_ZERO, OP_ADD, R_TY);
      6'd23: u = ppv_mk(5'd0,  A_TY,  B_HY,   BASE_ZERO, OP_ADD, R_TY);
      6'd24: u = ppv_mk(5'd19, A_MEM, B_ONE,  BASE_HY,   OP_ADD, R_SY);
      6'd25: u = ppv_mk(5'd23, A_MEM, B_ONE,  BASE_ZERO, OP_ADD, R_D);
      6'd26: u = ppv_mk(5'd22, A_MEM, B_ONE,  BASE_DST,  OP_SUB, R_D);
      6'd27: u = ppv_mk(5'd0,  A_D,   B_CZ,   BASE_ZERO, OP_ADD, R_D);
      // scale by the reciprocal and finish
      6'd28: u = ppv_mk(5'd0,  A_TX,  B_W,    BASE_ZERO, OP_ADD, R_TX);
      6'd29: u = ppv_mk(5'd0,  A_TX,  B_ONE,  BASE_DST,  OP_ADD, R_SX);
      6'd30: u = ppv_mk(5'd0,  A_TY,  B_W,    BASE_ZERO, OP_ADD, R_TY);
      6'd31: u = ppv_mk(5'd0,  A_TY,  B_ONE,  BASE_DST,  OP_ADD, R_SY);
      6'd32: u = ppv_mk(5'd0,  A_D,   B_W,    BASE_ZERO, OP_ADD, R_D);
      6'd33: u = ppv_mk(5'd23, A_MEM, B_ONE,  BASE_DST,  OP_ADD, R_D);
      default: u = ppv_mk(5'd0, A_MEM, B_ONE, BASE_ZERO, OP_ADD, R_D);
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/ppv_in_if.sv =====
// Input channel: coefficient writes and points to project.
interface ppv_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [4:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, command, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, command, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

// ===== hw/rtl/ppv_out_if.sv =====
// Output channel: projected screen coordinates.
interface ppv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] screen_depth;

  modport source (output valid, screen_x, screen_y, screen_depth, input ready);
  modport sink   (input valid, screen_x, screen_y, screen_depth, output ready);
endinterface

// ===== hw/rtl/ppv_recip.sv =====
// Bit-serial reciprocal unit: 2^(2F) / d, truncated toward zero, saturated to 32 bits.
`include "perspective_project_viewport_assert.svh"
module ppv_recip #(
  parameter int FRACTION_BITS = ppv_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] divisor,
  output logic               busy,
  output logic signed [31:0] quotient
);
  import ppv_pkg::*;

  localparam int QW = 2 * FRACTION_BITS + 1;
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt;
  logic          run;
  logic          fin;
  logic          neg;
  logic [31:0]   mag;
  logic [31:0]   rem;
  logic [QW-1:0] quo;
  logic [32:0]   trial;
  logic          fits;
  logic [63:0]   q_wide;
  logic [63:0]   q_neg;

  // Shift in the next dividend bit; only the top bit of the dividend is set
  assign trial  = {rem, (cnt == CW'(QW))};
  assign fits   = trial >= {1'b0, mag};
  assign q_wide = 64'(quo);
  assign q_neg  = -q_wide;
  assign busy   = run | fin;

  // Control: count down the quotient bits, then raise fin to saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(QW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring division one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mag <= divisor[31] ? 32'(-divisor) : divisor;
      neg <= divisor[31];
      rem <= '0;
      quo <= '0;
    end else if (run) begin
      rem <= fits ? 32'(trial - {1'b0, mag}) : trial[31:0];
      quo <= {quo[QW-2:0], fits};
    end
    if (fin) begin
      if (neg) begin
        quotient <= (q_wide > 64'h8000_0000) ? INT_MIN : q_neg[31:0];
      end else begin
        quotient <= (q_wide > 64'h7FFF_FFFF) ? INT_MAX : q_wide[31:0];
      end
    end
  end

  `PPV_ASSERT_NR(a_recip_reset_idle, clk, rst |=> !busy)
  `PPV_ASSERT(a_recip_start_runs, clk, rst, start |=> (run && cnt == CW'(QW)))
  `PPV_ASSERT(a_recip_fin_once, clk, rst, (fin && !start) |=> !busy)

endmodule

// ===== hw/rtl/perspective_project_viewport.sv =====
// Vertex projection engine: coefficient store, step sequencer, shared multiplier.
//
// Usage: one input channel (req) carries transactions of two kinds. A write
// transaction (command 0) stores coef_value into coefficient entry coef_index
// (0-11 view matrix row-major, 12-17 projection terms, 18-23 viewport terms);
// an index above 23 is dropped. It produces no output.
// A project transaction (command 1) maps point_x/y/z to screen_x/y/depth and
// produces one output transaction on rsp. All values are signed Q16.16 by
// default (FRACTION_BITS), products floored, every step saturated.
// A project transaction runs 34 steps, each in ST_MUL then ST_ACC, on the one
// 32x32 multiplier, reading coefficients from the coefficient memory. Before
// the first step that scales by the reciprocal it waits in ST_WAIT while the
// reciprocal unit (1/(-eye z) in Q16.16, started once eye z is known) is busy,
// and it ends in ST_OUT. A point with eye z zero skips the rest: (0, 0, -2.0).
// One transaction is in flight at a time; req is ready only while idle.
// The result sits in an output register, so the next transaction is taken
// while it waits; a finished result holds until that register is free.
// Reset makes every coefficient read as zero and empties the output register.
`include "perspective_project_viewport_assert.svh"
module perspective_project_viewport #(
  parameter int FRACTION_BITS = ppv_pkg::FRACTION_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  ppv_in_if.sink   req,
  ppv_out_if.source rsp
);
  import ppv_pkg::*;

  localparam logic signed [31:0] ONE     = 32'(1 << FRACTION_BITS);
  localparam logic signed [31:0] HALF    = 32'(1 << (FRACTION_BITS - 1));
  localparam logic signed [31:0] NEG_ONE = 32'(-(1 << FRACTION_BITS));
  localparam logic signed [31:0] NEG_TWO = 32'(-(2 << FRACTION_BITS));

  ppv_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  ppv_uop_t          uop_cur, uop_rd;

  logic                   in_fire;
  logic                   wr_en;
  logic [31:0]            coef_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] coef_valid;
  logic [31:0]            rd_q;
  logic                   rd_valid;
  logic signed [31:0]     coef;

  logic signed [31:0] px, py, pz;
  logic signed [31:0] ex, ey, ez, cx, cy, cz, hx, hy, tx, ty, sx, sy, dz;
  logic signed [31:0] a_op, b_op, base_val, dst_val, mulres, comb_res, neg_ez;
  logic signed [63:0] prod;
  logic signed [32:0] sum;

  logic               acc_en, zero_hit, load_out, div_start, div_busy;
  logic signed [31:0] w;

  logic               out_valid;
  logic signed [31:0] out_x, out_y, out_z;

  assign in_fire   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign wr_en     = in_fire && (req.command == CMD_WRITE) &&
                     (req.coef_index < IDX_W'(STORE_DEPTH));

  assign uop_cur = ppv_prog(step);
  assign uop_rd  = ppv_prog(step_next);

  // Coefficient memory: read address follows the step about to run
  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[req.coef_index] <= req.coef_value;
    end
    rd_q     <= coef_mem[uop_rd.addr];
    rd_valid <= coef_valid[uop_rd.addr];
  end

  // Entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= '0;
    end else if (wr_en) begin
      coef_valid[req.coef_index] <= 1'b1;
    end
  end

  assign coef = rd_valid ? $signed(rd_q) : '0;

  // Operand select
  always_comb begin
    case (uop_cur.asel)
      A_MEM:   a_op = coef;
      A_CX:    a_op = cx;
      A_CY:    a_op = cy;
      A_TX:    a_op = tx;
      A_TY:    a_op = ty;
      A_D:     a_op = dz;
      default: a_op = '0;
    endcase
    case (uop_cur.bsel)
      B_X:     b_op = px;
      B_Y:     b_op = py;
      B_Z:     b_op = pz;
      B_ONE:   b_op = ONE;
      B_HALF:  b_op = HALF;
      B_NEG:   b_op = NEG_ONE;
      B_EX:    b_op = ex;
      B_EY:    b_op = ey;
      B_EZ:    b_op = ez;
      B_HX:    b_op = hx;
      B_HY:    b_op = hy;
      B_CZ:    b_op = cz;
      B_W:     b_op = w;
      default: b_op = '0;
    endcase
  end

  // Accumulate: floor-shift and saturate the product, add it to or subtract it from the base
  always_comb begin
    case (uop_cur.dst)
      R_EX:    dst_val = ex;
      R_EY:    dst_val = ey;
      R_EZ:    dst_val = ez;
      R_CX:    dst_val = cx;
      R_CY:    dst_val = cy;
      R_CZ:    dst_val = cz;
      R_HX:    dst_val = hx;
      R_HY:    dst_val = hy;
      R_TX:    dst_val = tx;
      R_TY:    dst_val = ty;
      R_SX:    dst_val = sx;
      R_SY:    dst_val = sy;
      R_D:     dst_val = dz;
      default: dst_val = '0;
    endcase
    case (uop_cur.base)
      BASE_ZERO: base_val = '0;
      BASE_DST:  base_val = dst_val;
      BASE_HX:   base_val = hx;
      BASE_HY:   base_val = hy;
      default:   base_val = '0;
    endcase
    mulres = sat_wide(prod >>> FRACTION_BITS);
    if (uop_cur.op == OP_ADD) begin
      sum = 33'(base_val) + 33'(mulres);
    end else begin
      sum = 33'(base_val) - 33'(mulres);
    end
    comb_res = sat33(sum);
    neg_ez   = (comb_res == INT_MIN) ? INT_MAX : -comb_res;
  end

  // Sequencer: next state and step
  always_comb begin
    state_next = state;
    step_next  = step;
    acc_en     = 1'b0;
    zero_hit   = 1'b0;
    load_out   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire && req.command == CMD_PROJECT) begin
          step_next  = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        acc_en = 1'b1;
        if (step == STEP_EZ_DONE && comb_res == '0) begin
          zero_hit   = 1'b1;
          state_next = ST_OUT;
        end else if (step == STEP_LAST) begin
          state_next = ST_OUT;
        end else begin
          step_next = step + STEP_W'(1);
          div_start = (step == STEP_EZ_DONE);
          if (step_next == STEP_FIRST_W && div_busy) begin
            state_next = ST_WAIT;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_WAIT: begin
        if (!div_busy) begin
          state_next = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Hold the point, form the product, write back the step result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      px <= req.point_x;
      py <= req.point_y;
      pz <= req.point_z;
    end
    prod <= a_op * b_op;
    if (acc_en) begin
      case (uop_cur.dst)
        R_EX:    ex <= comb_res;
        R_EY:    ey <= comb_res;
        R_EZ:    ez <= comb_res;
        R_CX:    cx <= comb_res;
        R_CY:    cy <= comb_res;
        R_CZ:    cz <= comb_res;
        R_HX:    hx <= comb_res;
        R_HY:    hy <= comb_res;
        R_TX:    tx <= comb_res;
        R_TY:    ty <= comb_res;
        R_SX:    sx <= comb_res;
        R_SY:    sy <= comb_res;
        R_D:     dz <= comb_res;
        default: dz <= comb_res;
      endcase
    end
    if (zero_hit) begin
      sx <= '0;
      sy <= '0;
      dz <= NEG_TWO;
    end
  end

  ppv_recip #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (neg_ez),
    .busy     (div_busy),
    .quotient (w)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x <= sx;
      out_y <= sy;
      out_z <= dz;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.screen_x     = out_x;
  assign rsp.screen_y     = out_y;
  assign rsp.screen_depth = out_z;

  `PPV_ASSERT(a_div_start_idle, clk, rst, div_start |-> !div_busy)
  `PPV_ASSERT(a_w_ready, clk, rst, (state == ST_MUL && uop_cur.bsel == B_W) |-> !div_busy)
  `PPV_ASSERT(a_out_no_overwrite, clk, rst, load_out |-> (!out_valid || rsp.ready))
  `PPV_ASSERT(a_project_starts, clk, rst,
    (in_fire && req.command == CMD_PROJECT) |=> (state == ST_MUL && step == '0))

endmodule
